[sv/mcd_pkg.sv]
// Shared types and constants for the memory character device block.
package mcd_pkg;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	localparam logic       REQ_READ  = 1'b0;
	localparam logic       REQ_WRITE = 1'b1;

	localparam logic [1:0] DEV_NULL   = 2'd0;
	localparam logic [1:0] DEV_ZERO   = 2'd1;
	localparam logic [1:0] DEV_FULL   = 2'd2;
	localparam logic [1:0] DEV_RANDOM = 2'd3;

	localparam logic       STAT_OK       = 1'b0;
	localparam logic       STAT_NO_SPACE = 1'b1;

	localparam logic [3:0] MAX_BYTES = 4'd8;

	typedef struct packed {
		logic       hold_req;
		logic       use_held;
		logic       load_out;
		logic       seed_init;
		logic       mix_add;
		logic       mix_xor;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       mul_b;
		logic       store_word;
		logic [1:0] word_idx;
	} cmd_t;

	typedef struct packed {
		logic need_seed;
		logic out_busy;
	} sts_t;

endpackage

[sv/mcd_dp.sv]
// Datapath: request decode, xoshiro256** state, splitmix64 seeding unit, output register.
module mcd_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             seed_wr_en,
	input  logic [63:0]      seed_wr_data,
	input  logic [7:0]       s_tdata,
	input  logic [2:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [71:0]      m_tdata,
	output logic [0:0]       m_tuser,
	input  mcd_pkg::cmd_t    cmd,
	output mcd_pkg::sts_t    sts
);
	import mcd_pkg::*;

	logic [63:0] seed_q;
	logic [63:0] rng_q [4];
	logic        req_type_q;
	logic [1:0]  kind_q;
	logic [3:0]  cnt_q;
	logic [63:0] mix_s_q;
	logic [63:0] mix_z_q;
	logic [63:0] acc_q;
	logic        out_vld_q;
	logic [63:0] out_data_q;
	logic [3:0]  out_done_q;
	logic        out_stat_q;

	logic        cur_type;
	logic [1:0]  cur_kind;
	logic [3:0]  cur_cnt;
	logic [3:0]  cnt_sat;
	logic        rng_zero;
	logic        rand_read;
	logic [63:0] m5;
	logic [63:0] r7;
	logic [63:0] word;
	logic [63:0] n0, n1, n2, n3;
	logic [63:0] byte_mask;
	logic [63:0] res_data;
	logic [3:0]  res_done;
	logic        res_stat;
	logic [63:0] mix_sum;
	logic [63:0] mul_const;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod;

	assign cur_type = cmd.use_held ? req_type_q : s_tuser[0];
	assign cur_kind = cmd.use_held ? kind_q : s_tuser[2:1];
	assign cur_cnt  = cmd.use_held ? cnt_q : s_tdata[3:0];
	assign cnt_sat  = (cur_cnt > MAX_BYTES) ? MAX_BYTES : cur_cnt;

	assign rng_zero  = ~|(rng_q[0] | rng_q[1] | rng_q[2] | rng_q[3]);
	assign rand_read = (cur_type == REQ_READ) && (cur_kind == DEV_RANDOM) && (cnt_sat != 4'd0);

	assign sts.need_seed = rand_read && rng_zero;
	assign sts.out_busy  = out_vld_q && !m_tready;

	// xoshiro256** output and state update
	assign m5   = rng_q[1] + {rng_q[1][61:0], 2'b00};
	assign r7   = {m5[56:0], m5[63:57]};
	assign word = r7 + {r7[60:0], 3'b000};
	assign n2   = rng_q[2] ^ rng_q[0];
	assign n3   = rng_q[3] ^ rng_q[1];
	assign n1   = rng_q[1] ^ n2;
	assign n0   = rng_q[0] ^ n3;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			byte_mask[b*8 +: 8] = (4'(b) < cnt_sat) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		res_data = 64'd0;
		res_done = 4'd0;
		res_stat = STAT_OK;
		if (cur_type == REQ_WRITE) begin
			if (cur_kind == DEV_FULL) begin
				res_stat = STAT_NO_SPACE;
			end else begin
				res_done = cnt_sat;
			end
		end else begin
			case (cur_kind)
				DEV_ZERO, DEV_FULL: res_done = cnt_sat;
				DEV_RANDOM: begin
					res_done = cnt_sat;
					res_data = word & byte_mask;
				end
				default: res_done = 4'd0;
			endcase
		end
	end

	// splitmix64 seeding: 64x64 multiply as three 32x32 partial products
	assign mix_sum   = mix_s_q + GOLDEN_GAMMA;
	assign mul_const = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_x     = (cmd.mul_step == 2'd2) ? mix_z_q[63:32] : mix_z_q[31:0];
	assign mul_y     = (cmd.mul_step == 2'd1) ? mul_const[63:32] : mul_const[31:0];
	assign prod      = 64'(mul_x) * 64'(mul_y);

	always_ff @(posedge clk) begin
		if (cmd.hold_req) begin
			req_type_q <= s_tuser[0];
			kind_q     <= s_tuser[2:1];
			cnt_q      <= s_tdata[3:0];
		end
		if (cmd.seed_init) begin
			mix_s_q <= seed_q ^ GOLDEN_GAMMA;
		end else if (cmd.mix_add) begin
			mix_s_q <= mix_sum;
		end
		if (cmd.mix_add) begin
			mix_z_q <= mix_sum ^ (mix_sum >> 30);
		end else if (cmd.mix_xor) begin
			mix_z_q <= acc_q ^ (acc_q >> 27);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_step == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
		if (cmd.load_out) begin
			out_data_q <= res_data;
			out_done_q <= res_done;
			out_stat_q <= res_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= 64'd0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				rng_q[i] <= 64'd0;
			end
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			if (cmd.store_word) begin
				rng_q[cmd.word_idx] <= acc_q ^ (acc_q >> 31);
			end else if (cmd.load_out && rand_read) begin
				rng_q[0] <= n0;
				rng_q[1] <= n1;
				rng_q[2] <= n2 ^ {rng_q[1][46:0], 17'd0};
				rng_q[3] <= {n3[18:0], n3[63:19]};
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_done_q, out_data_q};
	assign m_tuser  = out_stat_q;

endmodule

[sv/mcd_ctrl.sv]
// Controller: accepts beats and sequences the splitmix64 seeding steps.
module mcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output mcd_pkg::cmd_t cmd,
	input  mcd_pkg::sts_t sts
);
	import mcd_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SINIT  = 7'b0000010,
		ST_SADD   = 7'b0000100,
		ST_SMUL   = 7'b0001000,
		ST_SXOR   = 7'b0010000,
		ST_SSTORE = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] phase_q;
	logic       second_q;
	logic [1:0] word_q;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.mul_step = phase_q;
		cmd.mul_b    = second_q;
		cmd.word_idx = word_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !sts.out_busy;
				if (s_tvalid && !sts.out_busy) begin
					cmd.hold_req = 1'b1;
					if (sts.need_seed) begin
						state_d = ST_SINIT;
					end else begin
						cmd.load_out = 1'b1;
					end
				end
			end
			ST_SINIT: begin
				cmd.seed_init = 1'b1;
				state_d       = ST_SADD;
			end
			ST_SADD: begin
				cmd.mix_add = 1'b1;
				state_d     = ST_SMUL;
			end
			ST_SMUL: begin
				cmd.mul_en = 1'b1;
				if (phase_q == 2'd2) begin
					state_d = second_q ? ST_SSTORE : ST_SXOR;
				end
			end
			ST_SXOR: begin
				cmd.mix_xor = 1'b1;
				state_d     = ST_SMUL;
			end
			ST_SSTORE: begin
				cmd.store_word = 1'b1;
				state_d        = (word_q == 2'd3) ? ST_FINISH : ST_SADD;
			end
			ST_FINISH: begin
				cmd.use_held = 1'b1;
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= 2'd0;
			second_q <= 1'b0;
			word_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SMUL) begin
				phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
			end
			if (state_q == ST_SADD) begin
				second_q <= 1'b0;
			end else if (state_q == ST_SXOR) begin
				second_q <= 1'b1;
			end
			if (state_q == ST_SINIT) begin
				word_q <= 2'd0;
			end else if (state_q == ST_SSTORE) begin
				word_q <= word_q + 2'd1;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SMUL |-> phase_q != 2'd3)
		else $error("multiply phase out of range");

	a_init_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SINIT |=> state_q == ST_SADD && word_q == 2'd0 && !second_q)
		else $error("seeding did not start at word zero");

	a_last_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SSTORE && word_q == 2'd3) |=> state_q == ST_FINISH)
		else $error("seeding did not finish after fourth word");

endmodule

[sv/memory_char_device_with_prng_top.sv]
// Top level of the memory character device block with xoshiro256** random source.
//
// Input channel s_*: one beat is one access of up to eight bytes to the null,
// zero, full or random device. Output channel m_*: one result beat per access,
// carrying the read bytes, the byte count done and the status flag.
// seed_wr_en/seed_wr_data write the seed register used for lazy seeding; write
// it only while the block is idle.
// Latency and throughput: an access that needs no seeding is registered at the
// accepting edge, so its result is valid the next cycle and one access per
// cycle is sustained while m_tready is high. A random read that finds the
// generator state all zero first runs four splitmix64 steps on one shared
// 32x32 multiplier before its result appears, and no beat is taken meanwhile.
// Reset clears the generator state (unseeded), the seed register and the
// output valid flag. When m_tready is low the result beat holds and s_tready
// drops until the held beat is taken.
module memory_char_device_with_prng_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr_en,
	input  logic [63:0] seed_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] byte_count, [7:4] zero
	input  logic [2:0]  s_tuser,   // [0] req_type, [2:1] device_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] read_data, [67:64] done_count, [71:68] zero
	output logic [0:0]  m_tuser    // [0] status
);
	import mcd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mcd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_wr_en   (seed_wr_en),
		.seed_wr_data (seed_wr_data),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
